/* rtl/bpl_pkg.sv */
// bpl_pkg: shared sizes, codes and types for the bounded positional list
// used by the channel interfaces, the front decode/queue and the back executor
// no dependencies
package bpl_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths of the channels
    localparam int KIND_W  = 3;
    localparam int POS_W   = 5;
    localparam int FIELD_W = 32;
    localparam int STAT_W  = 2;
    localparam int ENT_W   = 5;

    // derived sizes
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command kind codes on the input channel
    localparam logic [KIND_W-1:0] KIND_ADD_HEAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_TAIL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_AT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_HEAD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DEL_TAIL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUMP     = 3'd5;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [2:0] {
        OP_ADD_HEAD,
        OP_ADD_TAIL,
        OP_ADD_AT,
        OP_DEL_HEAD,
        OP_DEL_TAIL,
        OP_DUMP,
        OP_NOP
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_DUMP
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        word_t            value;
    } cmd_t;

    // head of the command queue as seen by the back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // stored words keep the low DATA_WIDTH bits of the sign-extended field
    function automatic word_t to_word(input logic signed [FIELD_W-1:0] v);
        return DATA_WIDTH'(v);
    endfunction

endpackage

/* rtl/bpl_if.sv */
// bpl_in_if / bpl_out_if: valid/ready channels for command and result beats
// depends on bpl_pkg for field widths
interface bpl_in_if import bpl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [FIELD_W-1:0] value_in;

    modport source (output valid, output kind, output position, output value_in,
                    input ready);
    modport sink   (input valid, input kind, input position, input value_in,
                    output ready);
endinterface

interface bpl_out_if import bpl_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [FIELD_W-1:0] value_out;
    logic [ENT_W-1:0]          entry_index;
    logic [ENT_W-1:0]          entry_count;
    logic                      last;

    modport source (output valid, output status, output value_out,
                    output entry_index, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input value_out,
                    input entry_index, input entry_count, input last,
                    output ready);
endinterface

/* rtl/bpl_front.sv */
// bpl_front: takes command beats, decodes the kind into an operation and
// holds them in a short queue for the back; depends on bpl_pkg, bpl_in_if
module bpl_front import bpl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    bpl_in_if.sink      cmd,
    output q_head_t     head,
    input  logic        head_ready
);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              dec;
    logic              push;
    logic              pop;

    always_comb
    begin
        dec.position = cmd.position;
        dec.value    = to_word(cmd.value_in);
        unique case (cmd.kind)
            KIND_ADD_HEAD: dec.op = OP_ADD_HEAD;
            KIND_ADD_TAIL: dec.op = OP_ADD_TAIL;
            KIND_ADD_AT:   dec.op = OP_ADD_AT;
            KIND_DEL_HEAD: dec.op = OP_DEL_HEAD;
            KIND_DEL_TAIL: dec.op = OP_DEL_TAIL;
            KIND_DUMP:     dec.op = OP_DUMP;
            default:       dec.op = OP_NOP;
        endcase
    end

    assign cmd.ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = cmd.valid && cmd.ready;
    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_mem_reg[rd_ptr_reg];
    assign pop        = head.valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= dec;
        end
    end

    // queue bookkeeping
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count past depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

/* rtl/bpl_back.sv */
// bpl_back: holds the shift array of entries and the fill count, executes
// queued commands and drives the registered result channel
// depends on bpl_pkg, bpl_out_if
module bpl_back import bpl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  q_head_t     head,
    output logic        head_ready,
    bpl_out_if.source   rsp
);

    word_t             ent_reg [CAPACITY];
    word_t             ent_new [CAPACITY];
    word_t             up_src  [CAPACITY];
    word_t             dn_src  [CAPACITY];
    logic [CNT_W-1:0]  fill_reg, fill_new;
    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  dump_idx_reg, dump_idx_next;

    logic                      out_valid_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [FIELD_W-1:0]        value_reg;
    logic [ENT_W-1:0]          index_reg;
    logic [ENT_W-1:0]          count_reg;
    logic                      last_reg;

    logic                      out_free;
    logic                      start;
    logic                      dump_last;
    logic                      full;
    logic                      empty;
    status_t                   st;
    logic                      ins;
    logic                      del_h;
    logic                      del_t;
    logic [CNT_W-1:0]          slot;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          fill_ext;
    logic                      bad_pos;

    logic                      out_load;
    logic [STAT_W-1:0]         out_status;
    logic [FIELD_W-1:0]        out_value;
    logic [ENT_W-1:0]          out_index;
    logic [ENT_W-1:0]          out_count;
    logic                      out_last;

    // neighbor taps for the entry shifts
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_taps
        if (g == 0)
        begin : g_first
            assign up_src[g] = ent_reg[g];
        end
        else
        begin : g_rest
            assign up_src[g] = ent_reg[g-1];
        end
        if (g == CAPACITY - 1)
        begin : g_end
            assign dn_src[g] = ent_reg[g];
        end
        else
        begin : g_mid
            assign dn_src[g] = ent_reg[g+1];
        end
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign start     = (state_reg == BK_IDLE) && head.valid && out_free;
    assign dump_last = (CNT_W'(dump_idx_reg) + CNT_W'(1)) == fill_reg;
    assign full      = (fill_reg == CNT_W'(CAPACITY));
    assign empty     = (fill_reg == '0);
    assign pos_ext   = CMP_W'(head.cmd.position);
    assign fill_ext  = CMP_W'(fill_reg);
    assign bad_pos   = (pos_ext == '0) || (pos_ext > fill_ext + CMP_W'(1));

    // status and effect of the command at the queue head
    always_comb
    begin
        st    = ST_OK;
        ins   = 1'b0;
        del_h = 1'b0;
        del_t = 1'b0;
        slot  = '0;
        unique case (head.cmd.op)
            OP_ADD_HEAD:
            begin
                if (full) st = ST_FULL;
                else      ins = 1'b1;
            end
            OP_ADD_TAIL:
            begin
                slot = fill_reg;
                if (full) st = ST_FULL;
                else      ins = 1'b1;
            end
            OP_ADD_AT:
            begin
                slot = CNT_W'(pos_ext - CMP_W'(1));
                if (full)         st = ST_FULL;
                else if (bad_pos) st = ST_BADPOS;
                else              ins = 1'b1;
            end
            OP_DEL_HEAD:
            begin
                if (empty) st = ST_EMPTY;
                else       del_h = 1'b1;
            end
            OP_DEL_TAIL:
            begin
                if (empty) st = ST_EMPTY;
                else       del_t = 1'b1;
            end
            OP_DUMP, OP_NOP:
            begin
                st = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ent_new[i] = ent_reg[i];
            if (ins)
            begin
                if (CNT_W'(i) == slot)
                    ent_new[i] = head.cmd.value;
                else if (CNT_W'(i) > slot && CNT_W'(i) <= fill_reg)
                    ent_new[i] = up_src[i];
            end
            else if (del_h)
            begin
                if (CNT_W'(i + 1) < fill_reg)
                    ent_new[i] = dn_src[i];
            end
        end
        fill_new = fill_reg;
        if (ins)
            fill_new = fill_reg + 1'b1;
        else if (del_h || del_t)
            fill_new = fill_reg - 1'b1;
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        dump_idx_next = dump_idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (start && head.cmd.op == OP_DUMP && fill_reg > CNT_W'(1))
                begin
                    state_next    = BK_DUMP;
                    dump_idx_next = IDX_W'(1);
                end
            end
            BK_DUMP:
            begin
                if (out_free)
                begin
                    if (dump_last) state_next = BK_IDLE;
                    else           dump_idx_next = dump_idx_reg + 1'b1;
                end
            end
        endcase
    end

    // outputs
    always_comb
    begin
        head_ready = 1'b0;
        out_load   = 1'b0;
        out_status = ST_OK;
        out_value  = '0;
        out_index  = '0;
        out_count  = ENT_W'(fill_new);
        out_last   = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                head_ready = out_free;
                if (start)
                begin
                    out_load = 1'b1;
                    if (head.cmd.op == OP_DUMP && !empty)
                    begin
                        out_value = FIELD_W'(ent_reg[0]);
                        out_index = ENT_W'(1);
                        out_count = ENT_W'(fill_reg);
                        out_last  = (fill_reg == CNT_W'(1));
                    end
                    else
                    begin
                        out_status = st;
                    end
                end
            end
            BK_DUMP:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    out_value = FIELD_W'(ent_reg[dump_idx_reg]);
                    out_index = ENT_W'(CNT_W'(dump_idx_reg) + CNT_W'(1));
                    out_count = ENT_W'(fill_reg);
                    out_last  = dump_last;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            dump_idx_reg  <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            dump_idx_reg <= dump_idx_next;
            if (start)
                fill_reg <= fill_new;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < CAPACITY; i++)
                ent_reg[i] <= ent_new[i];
        end
        if (out_load)
        begin
            status_reg <= out_status;
            value_reg  <= out_value;
            index_reg  <= out_index;
            count_reg  <= out_count;
            last_reg   <= out_last;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.value_out   = value_reg;
    assign rsp.entry_index = index_reg;
    assign rsp.entry_count = count_reg;
    assign rsp.last        = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count past capacity");

    a_dump_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DUMP) |-> (fill_reg > CNT_W'(1) && CNT_W'(dump_idx_reg) < fill_reg))
        else $error("dump index outside the list");

    a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !start |=> $stable(fill_reg))
        else $error("fill count moved without a command");

    a_no_pop_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DUMP) |-> !head_ready)
        else $error("queue popped during a dump");

endmodule

/* rtl/bounded_positional_list.sv */
// bounded_positional_list: ordered list of up to CAPACITY signed words
// add/delete: a command passes the queue, then its result beat is registered;
// one command per cycle sustained through the two-deep queue unless results
// stall or a dump runs; dump: max(fill, 1) result beats, one per cycle unless
// results stall, from the single entry read port; reset clears the fill count,
// the command queue and the result register; entry contents are left unset
module bounded_positional_list import bpl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    bpl_in_if.sink      cmd,
    bpl_out_if.source   rsp
);

    q_head_t head;
    logic    head_ready;

    bpl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_ready (head_ready)
    );

    bpl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_ready (head_ready),
        .rsp        (rsp)
    );

endmodule

/* tb/bounded_positional_list_checker.sv */
`timescale 1ns / 100ps
// bounded_positional_list_checker: watches the command and result channels of the list
// keeps its own copy of the entries and fill count, predicts each result beat and compares
// depends on bpl_pkg and the bpl_in_if / bpl_out_if interfaces
module bounded_positional_list_checker import bpl_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bpl_in_if    cmd,
    bpl_out_if   rsp,
    output int   mismatch_count,
    output int   pending,
    output int   list_fill
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t                   status;
        logic signed [FIELD_W-1:0] value;
        logic [ENT_W-1:0]          index;
        logic [ENT_W-1:0]          count;
        logic                      last;
    } list_beat_t;

    word_t      list_words [CAPACITY];
    int         fill_n;
    list_beat_t due_beats [$];

    assign list_fill = fill_n;

    // shift the tail down by one and drop the word into the freed slot
    function automatic status_t insert_word(int slot, word_t w);
        if (fill_n >= CAPACITY)
            return ST_FULL;
        if (slot > fill_n)
            return ST_BADPOS;
        for (int i = fill_n; i > slot; i--)
            list_words[i] = list_words[i - 1];
        list_words[slot] = w;
        fill_n++;
        return ST_OK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        list_beat_t seen;
        list_beat_t due;
        status_t    st;
        word_t      w;
        if (!rst_n)
        begin
            due_beats.delete();
            fill_n         = 0;
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            // result beats first: a command taken at this edge cannot answer yet
            if (rsp.valid && rsp.ready)
            begin
                seen = '{status_t'(rsp.status), rsp.value_out, rsp.entry_index,
                         rsp.entry_count, rsp.last};
                if (due_beats.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result beat: status %0d value %h",
                                 seen.status, seen.value,
                                 " index %0d count %0d last %b",
                                 seen.index, seen.count, seen.last);
                end
                else
                begin
                    due = due_beats.pop_front();
                    if (seen !== due)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("result mismatch: expected status %0d value %h",
                                     due.status, due.value,
                                     " index %0d count %0d last %b,",
                                     due.index, due.count, due.last,
                                     " got status %0d value %h",
                                     seen.status, seen.value,
                                     " index %0d count %0d last %b",
                                     seen.index, seen.count, seen.last);
                    end
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                st = ST_OK;
                w  = word_t'(cmd.value_in);
                case (cmd.kind)
                    KIND_ADD_HEAD: st = insert_word(0, w);
                    KIND_ADD_TAIL: st = insert_word(fill_n, w);
                    KIND_ADD_AT:
                    begin
                        // full is flagged ahead of a bad position
                        if (fill_n >= CAPACITY)
                            st = ST_FULL;
                        else if (cmd.position == 0 || int'(cmd.position) > fill_n + 1)
                            st = ST_BADPOS;
                        else
                            st = insert_word(int'(cmd.position) - 1, w);
                    end
                    KIND_DEL_HEAD:
                    begin
                        if (fill_n == 0)
                            st = ST_EMPTY;
                        else
                        begin
                            for (int i = 0; i + 1 < fill_n; i++)
                                list_words[i] = list_words[i + 1];
                            fill_n--;
                        end
                    end
                    KIND_DEL_TAIL:
                    begin
                        if (fill_n == 0)
                            st = ST_EMPTY;
                        else
                            fill_n--;
                    end
                    KIND_DUMP:
                    begin
                        if (fill_n == 0)
                            due_beats.push_back('{ST_OK, '0, '0, '0, 1'b1});
                        for (int i = 0; i < fill_n; i++)
                            due_beats.push_back('{ST_OK, FIELD_W'(list_words[i]),
                                                  ENT_W'(i + 1), ENT_W'(fill_n),
                                                  (i + 1 == fill_n)});
                    end
                    default: ;
                endcase
                if (cmd.kind != KIND_DUMP)
                    due_beats.push_back('{st, '0, '0, ENT_W'(fill_n), 1'b1});
            end
            pending = due_beats.size();
        end
    end

endmodule

/* tb/bounded_positional_list_test.sv */
`timescale 1ns / 100ps
// bounded_positional_list_test: clock, reset, command stimulus and result back-pressure
// instantiates the list block and bounded_positional_list_checker, gives the verdict
// depends on bpl_pkg, bpl_in_if / bpl_out_if and the checker module
module bounded_positional_list_test;
    import bpl_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    localparam int RANDOM_ITEMS = 430;
    localparam int PHASES       = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 500000;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic quiet = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count;
    int   pending;
    int   list_fill;

    bpl_in_if  cmd_ch ();
    bpl_out_if rsp_ch ();

    bounded_positional_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    bounded_positional_list_checker list_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .list_fill      (list_fill)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL bounded_positional_list");
            $finish;
        end
    end

    // one command beat: optional gap, then hold until taken
    task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                            input logic signed [FIELD_W-1:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid    = 1'b1;
        cmd_ch.kind     = k;
        cmd_ch.position = p;
        cmd_ch.value_in = v;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        cmd_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // result side: a random stall ahead of every beat, none while quiet
    initial
    begin : result_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall > 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        mix_t                      mix;
        int                        r;
        int                        add_pct;
        logic [KIND_W-1:0]         k;
        logic [POS_W-1:0]          p;
        logic signed [FIELD_W-1:0] v;

        cmd_ch.valid    = 1'b0;
        cmd_ch.kind     = KIND_ADD_HEAD;
        cmd_ch.position = '0;
        cmd_ch.value_in = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty list corners, then bad positions, a fill to four entries and a drain
        send_cmd(KIND_DUMP, 0, 0);
        send_cmd(KIND_DEL_HEAD, 0, 0);
        send_cmd(KIND_DEL_TAIL, 0, 0);
        send_cmd(KIND_ADD_AT, 0, 5);
        send_cmd(KIND_ADD_AT, 2, 5);
        send_cmd(KIND_ADD_AT, 1, 32'sh7fffffff);
        send_cmd(KIND_ADD_HEAD, 0, 32'sh80000000);
        send_cmd(KIND_ADD_TAIL, 0, -1);
        send_cmd(KIND_ADD_AT, 31, 7);
        send_cmd(KIND_ADD_AT, 16, 7);
        send_cmd(KIND_ADD_AT, 4, 0);
        send_cmd(KIND_DUMP, 0, 0);
        send_cmd(KIND_UNUSED_LO, 3, 9);
        send_cmd(KIND_UNUSED_HI, 0, 9);
        send_cmd(KIND_DEL_HEAD, 0, 0);
        send_cmd(KIND_DEL_TAIL, 0, 0);
        send_cmd(KIND_DEL_TAIL, 0, 0);
        // one entry left: tail delete empties the list
        send_cmd(KIND_DEL_TAIL, 0, 0);
        send_cmd(KIND_DUMP, 0, 0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            mix   = mix_t'(ph % 3);
            quiet = (ph % 4 == 3);
            case (mix)
                MIX_GROW:   add_pct = 70;
                MIX_SHRINK: add_pct = 22;
                default:    add_pct = 43;
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                else if (r < 13)
                    k = KIND_DUMP;
                else if (r < 13 + add_pct)
                begin
                    case ($urandom_range(0, 2))
                        0:       k = KIND_ADD_HEAD;
                        1:       k = KIND_ADD_TAIL;
                        default: k = KIND_ADD_AT;
                    endcase
                end
                else
                    k = $urandom_range(0, 1) ? KIND_DEL_HEAD : KIND_DEL_TAIL;

                // mostly legal positions, now and then the whole field
                if ($urandom_range(0, 9) == 0)
                    p = POS_W'($urandom_range(0, 31));
                else
                    p = POS_W'($urandom_range(1, list_fill + 1));

                if ($urandom_range(0, 7) == 0)
                begin
                    case ($urandom_range(0, 4))
                        0:       v = 0;
                        1:       v = 1;
                        2:       v = -1;
                        3:       v = 32'sh7fffffff;
                        default: v = 32'sh80000000;
                    endcase
                end
                else
                    v = $urandom;

                send_cmd(k, p, v);
            end
            if (ph == PHASES / 2)
                wait_drained();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("PASS bounded_positional_list");
        else
            $display("FAIL bounded_positional_list");
        $finish;
    end

endmodule

/* bounded_positional_list.f */
rtl/bpl_pkg.sv
rtl/bpl_if.sv
rtl/bpl_front.sv
rtl/bpl_back.sv
rtl/bounded_positional_list.sv
tb/bounded_positional_list_checker.sv
tb/bounded_positional_list_test.sv
